// ===== rtl/spwm_pkg.sv =====
// Package for the three-phase sine PWM compare block: field widths, register
// indexes, reset values, the configuration struct and the cosine series helper.
// No dependencies.
package spwm_pkg;

  localparam int ANGLE_W    = 16;
  localparam int MOD_W      = 16;
  localparam int CMP_W      = 16;
  localparam int PERIOD_W   = 16;
  localparam int DUTY_W     = 17;
  localparam int DUTY_S_W   = 19;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 2;

  localparam int COS_TABLE_BITS_DEF = 10;
  localparam int COS_FRAC_BITS_DEF  = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMER_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_FLOOR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_CEILING = 2'd2;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 16'd1000;
  localparam logic [DUTY_W-1:0]   FLOOR_RESET   = 17'd0;
  localparam logic [DUTY_W-1:0]   CEILING_RESET = 17'd65536;

  localparam logic [ANGLE_W-1:0]          PHASE_120 = 16'd21845;
  localparam logic signed [DUTY_S_W-1:0] DUTY_HALF = 19'sd32768;
  localparam longint unsigned             HALF_PI_Q30 = 64'd1686629713;

  localparam longint unsigned COS_DIV [12] =
    '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
      64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552};

  typedef struct packed {
    logic [PERIOD_W-1:0] timer_period;
    logic [DUTY_W-1:0]   duty_floor;
    logic [DUTY_W-1:0]   duty_ceiling;
  } spwm_cfg_t;

  // Cosine of a Q30 angle by a 13-term Taylor series, evaluated at elaboration.
  function automatic longint cos_q30(input longint unsigned x);
    longint          sum;
    longint unsigned term;
    sum  = 64'sd1 <<< 30;
    term = 64'd1 << 30;
    for (int k = 1; k <= 12; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / COS_DIV[k-1];
      if (k[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    return sum;
  endfunction

endpackage

// ===== rtl/spwm_if.sv =====
// Valid/ready channel interfaces for the angle input and the compare output.
// Depends on spwm_pkg for the field widths.
interface spwm_angle_if;
  import spwm_pkg::*;
  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] elec_angle;
  logic [MOD_W-1:0]   mod_index;
  modport source (output valid, output elec_angle, output mod_index, input ready);
  modport sink   (input valid, input elec_angle, input mod_index, output ready);
endinterface

interface spwm_cmp_if;
  import spwm_pkg::*;
  logic             valid;
  logic             ready;
  logic [CMP_W-1:0] compare_u;
  logic [CMP_W-1:0] compare_v;
  logic [CMP_W-1:0] compare_w;
  modport source (output valid, output compare_u, output compare_v, output compare_w,
                  input ready);
  modport sink   (input valid, input compare_u, input compare_v, input compare_w,
                  output ready);
endinterface

// ===== rtl/spwm_phase.sv =====
// One phase of the compare pipeline: cosine ROM read, modulation multiply,
// duty clamp, period multiply and saturation. Depends on spwm_pkg.
module spwm_phase #(
  parameter int COS_TABLE_BITS = spwm_pkg::COS_TABLE_BITS_DEF,
  parameter int COS_FRAC_BITS  = spwm_pkg::COS_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            adv,
  input  logic [spwm_pkg::ANGLE_W-1:0]    angle,
  input  logic [spwm_pkg::MOD_W-1:0]      mod_index,
  input  spwm_pkg::spwm_cfg_t             cfg,
  output logic [spwm_pkg::CMP_W-1:0]      compare
);
  import spwm_pkg::*;

  localparam int ROM_LEN = (1 << COS_TABLE_BITS) + 1;
  localparam int ROM_W   = COS_FRAC_BITS + 1;
  localparam int AW      = COS_TABLE_BITS + 1;
  localparam int PW      = MOD_W + ROM_W;
  localparam int CPW     = DUTY_W + PERIOD_W;
  localparam logic [AW-1:0] LAST = AW'(ROM_LEN - 1);

  typedef logic [ROM_W-1:0] rom_t [ROM_LEN];

  function automatic rom_t build_rom();
    rom_t            r;
    longint          c;
    longint unsigned x;
    for (int i = 0; i < ROM_LEN - 1; i++) begin
      x = (HALF_PI_Q30 * 64'(i)) >> COS_TABLE_BITS;
      c = cos_q30(x);
      if (c < 0) begin
        c = 0;
      end
      r[i] = ROM_W'((64'(c) + (64'd1 << (29 - COS_FRAC_BITS))) >> (30 - COS_FRAC_BITS));
    end
    r[ROM_LEN-1] = '0;
    return r;
  endfunction

  localparam rom_t COS_ROM = build_rom();

  logic [COS_TABLE_BITS-1:0] idx;
  logic [AW-1:0]             addr;
  logic                      neg_in;

  logic [ROM_W-1:0] cos_mag;
  logic             neg1;
  logic [MOD_W-1:0] mod1;
  logic [PW-1:0]    prod;
  logic             neg2;
  logic [DUTY_W-1:0] duty;
  logic [CPW-1:0]   cmp_prod;

  logic signed [PW:0]          prod_s;
  logic signed [PW:0]          prod_sh;
  logic signed [DUTY_S_W-1:0]  duty_raw;
  logic signed [DUTY_S_W-1:0]  floor_s;
  logic signed [DUTY_S_W-1:0]  ceil_s;
  logic [DUTY_W-1:0]           duty_next;

  assign idx    = angle[ANGLE_W-3 -: COS_TABLE_BITS];
  assign addr   = angle[ANGLE_W-2] ? (LAST - {1'b0, idx}) : {1'b0, idx};
  assign neg_in = angle[ANGLE_W-1] ^ angle[ANGLE_W-2];

  always_comb begin
    prod_s   = neg2 ? -$signed({1'b0, prod}) : $signed({1'b0, prod});
    prod_sh  = prod_s >>> COS_FRAC_BITS;
    duty_raw = DUTY_S_W'(prod_sh) + DUTY_HALF;
    floor_s  = $signed({2'b00, cfg.duty_floor});
    ceil_s   = $signed({2'b00, cfg.duty_ceiling});
    if (duty_raw < floor_s) begin
      duty_next = cfg.duty_floor;
    end else if (duty_raw > ceil_s) begin
      duty_next = cfg.duty_ceiling;
    end else begin
      duty_next = duty_raw[DUTY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cos_mag  <= COS_ROM[addr];
      neg1     <= neg_in;
      mod1     <= mod_index;
      prod     <= PW'(mod1 * cos_mag);
      neg2     <= neg1;
      duty     <= duty_next;
      cmp_prod <= CPW'(duty * cfg.timer_period);
      compare  <= cmp_prod[CPW-1] ? {CMP_W{1'b1}} : cmp_prod[CPW-2 -: CMP_W];
    end
  end

endmodule

// ===== rtl/three_phase_sine_pwm_compare.sv =====
// Top level of the three-phase sine PWM compare block: configuration registers,
// phase offsets and the shared valid pipeline. Depends on spwm_pkg, spwm_if
// and spwm_phase.
//
// Usage: each transfer on angle_ch carries an electrical angle (65536 units
// per turn) and a Q1.15 modulation index. Exactly one transfer on cmp_ch
// follows with the compare counts for phases U, V (lagging 120 degrees) and
// W (leading 120 degrees), in input order.
// Each item passes through the registered steps cosine ROM read, modulation
// multiply, duty clamp, period multiply, then saturation into the output
// register, and output valid rises once it reaches the last of them. A new
// item is taken every cycle while the output is not stalled; each phase has
// its own ROM, so the three lookups run in parallel.
// When the receiver holds ready low with a result waiting, the whole pipeline
// holds and angle_ch.ready drops; nothing is lost or repeated.
// Configuration is written through cfg_we, cfg_index and cfg_wdata while the
// pipeline is empty. Reset (rst, synchronous) empties the pipeline and loads
// timer_period 1000, duty_floor 0 and duty_ceiling 65536. The ROMs are
// constant and need no fill after reset.
module three_phase_sine_pwm_compare #(
  parameter int COS_TABLE_BITS = spwm_pkg::COS_TABLE_BITS_DEF,
  parameter int COS_FRAC_BITS  = spwm_pkg::COS_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  spwm_angle_if.sink                      angle_ch,
  spwm_cmp_if.source                      cmp_ch,
  input  logic                            cfg_we,
  input  logic [spwm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spwm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import spwm_pkg::*;

  localparam int NUM_STAGES = 5;

  spwm_cfg_t               cfg;
  logic [NUM_STAGES-1:0]   vld;
  logic                    adv;
  logic [ANGLE_W-1:0]      angle_v;
  logic [ANGLE_W-1:0]      angle_w;

  assign adv            = !vld[NUM_STAGES-1] || cmp_ch.ready;
  assign angle_ch.ready = adv;
  assign cmp_ch.valid   = vld[NUM_STAGES-1];
  assign angle_v        = angle_ch.elec_angle - PHASE_120;
  assign angle_w        = angle_ch.elec_angle + PHASE_120;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timer_period <= PERIOD_RESET;
      cfg.duty_floor   <= FLOOR_RESET;
      cfg.duty_ceiling <= CEILING_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TIMER_PERIOD: cfg.timer_period <= cfg_wdata[PERIOD_W-1:0];
        CFG_DUTY_FLOOR:   cfg.duty_floor   <= cfg_wdata[DUTY_W-1:0];
        CFG_DUTY_CEILING: cfg.duty_ceiling <= cfg_wdata[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NUM_STAGES-2:0], angle_ch.valid};
    end
  end

  spwm_phase #(
    .COS_TABLE_BITS(COS_TABLE_BITS),
    .COS_FRAC_BITS (COS_FRAC_BITS)
  ) u_phase_u (
    .clk      (clk),
    .adv      (adv),
    .angle    (angle_ch.elec_angle),
    .mod_index(angle_ch.mod_index),
    .cfg      (cfg),
    .compare  (cmp_ch.compare_u)
  );

  spwm_phase #(
    .COS_TABLE_BITS(COS_TABLE_BITS),
    .COS_FRAC_BITS (COS_FRAC_BITS)
  ) u_phase_v (
    .clk      (clk),
    .adv      (adv),
    .angle    (angle_v),
    .mod_index(angle_ch.mod_index),
    .cfg      (cfg),
    .compare  (cmp_ch.compare_v)
  );

  spwm_phase #(
    .COS_TABLE_BITS(COS_TABLE_BITS),
    .COS_FRAC_BITS (COS_FRAC_BITS)
  ) u_phase_w (
    .clk      (clk),
    .adv      (adv),
    .angle    (angle_w),
    .mod_index(angle_ch.mod_index),
    .cfg      (cfg),
    .compare  (cmp_ch.compare_w)
  );

`ifndef NO_ASSERTIONS
  // An input transfer always lands in the first pipeline stage.
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    angle_ch.valid && angle_ch.ready |=> vld[0])
    else $error("accepted item did not enter the pipeline");

  // While the output is stalled, no stage moves.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !angle_ch.ready |=> $stable(vld))
    else $error("pipeline moved during a stall");

  // A write to an unused register index changes no configuration.
  a_bad_index: assert property (@(posedge clk) disable iff (rst)
    cfg_we && cfg_index != CFG_TIMER_PERIOD && cfg_index != CFG_DUTY_FLOOR &&
    cfg_index != CFG_DUTY_CEILING |=> $stable(cfg))
    else $error("write to an unused index changed the configuration");
`endif

endmodule

// ===== test/compare_count_checker.sv =====
// Checker for the three-phase sine PWM compare block. It watches the angle and
// compare channels and the register write port, predicts each compare set and
// compares it with what the block returns. Depends on spwm_pkg and spwm_if.
module compare_count_checker (
  input  logic                            clk,
  input  logic                            rst,
  spwm_angle_if                           angle_ch,
  spwm_cmp_if                             cmp_ch,
  input  logic                            cfg_we,
  input  logic [spwm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spwm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              mismatches,
  output int                              outstanding
);
  import spwm_pkg::*;

  localparam int TBL_BITS  = COS_TABLE_BITS_DEF;
  localparam int FRAC_BITS = COS_FRAC_BITS_DEF;
  localparam int ROM_LAST  = 1 << TBL_BITS;

  typedef logic [2:0][CMP_W-1:0] count_set_t;

  longint              quarter_cos [0:ROM_LAST];
  logic [PERIOD_W-1:0] period_cfg;
  logic [DUTY_W-1:0]   floor_cfg;
  logic [DUTY_W-1:0]   ceiling_cfg;
  count_set_t          pending_counts [$];
  count_set_t          want;
  count_set_t          got;
  byte                 tag;

  initial begin
    longint unsigned x;
    longint unsigned term;
    longint          sum;
    for (int i = 0; i < ROM_LAST; i++) begin
      x    = (HALF_PI_Q30 * i) >> TBL_BITS;
      sum  = 64'sd1 << 30;
      term = 64'd1 << 30;
      for (int k = 1; k <= 12; k++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / ((2 * k - 1) * (2 * k));
        if (k % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      quarter_cos[i] = (sum + (64'sd1 << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    end
    quarter_cos[ROM_LAST] = 0;
    mismatches = 0;
  end

  function automatic logic [CMP_W-1:0] phase_compare_count(input logic [ANGLE_W-1:0] phase,
                                                           input logic [MOD_W-1:0] m);
    int     idx;
    longint c;
    longint duty;
    longint lo;
    longint hi;
    longint scaled;
    idx = int'(phase[13:0]) >> (14 - TBL_BITS);
    case (phase[15:14])
      2'd0: c = quarter_cos[idx];
      2'd1: c = -quarter_cos[ROM_LAST - idx];
      2'd2: c = -quarter_cos[idx];
      default: c = quarter_cos[ROM_LAST - idx];
    endcase
    lo   = longint'({47'd0, floor_cfg});
    hi   = longint'({47'd0, ceiling_cfg});
    duty = 64'sd32768 + (($signed({48'd0, m}) * c) >>> FRAC_BITS);
    if (duty < lo) begin
      duty = lo;
    end else if (duty > hi) begin
      duty = hi;
    end
    scaled = (duty * longint'({48'd0, period_cfg})) >>> 16;
    if (scaled > 65535) begin
      return 16'hFFFF;
    end
    return scaled[CMP_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      pending_counts.delete();
      period_cfg  = PERIOD_RESET;
      floor_cfg   = FLOOR_RESET;
      ceiling_cfg = CEILING_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TIMER_PERIOD: period_cfg  = cfg_wdata[PERIOD_W-1:0];
          CFG_DUTY_FLOOR:   floor_cfg   = cfg_wdata[DUTY_W-1:0];
          CFG_DUTY_CEILING: ceiling_cfg = cfg_wdata[DUTY_W-1:0];
          default: ;
        endcase
      end
      if (angle_ch.valid && angle_ch.ready) begin
        want[0] = phase_compare_count(angle_ch.elec_angle, angle_ch.mod_index);
        want[1] = phase_compare_count(angle_ch.elec_angle - PHASE_120, angle_ch.mod_index);
        want[2] = phase_compare_count(angle_ch.elec_angle + PHASE_120, angle_ch.mod_index);
        pending_counts.push_back(want);
      end
      if (cmp_ch.valid && cmp_ch.ready) begin
        got = {cmp_ch.compare_w, cmp_ch.compare_v, cmp_ch.compare_u};
        if (pending_counts.size() == 0) begin
          $display("%0t: unexpected compare transfer, expected none, got %0d %0d %0d",
                   $time, got[0], got[1], got[2]);
          mismatches++;
        end else begin
          want = pending_counts.pop_front();
          for (int p = 0; p < 3; p++) begin
            if (got[p] !== want[p]) begin
              tag = (p == 0) ? "U" : (p == 1) ? "V" : "W";
              $display("%0t: phase %c compare expected %0d, got %0d",
                       $time, tag, want[p], got[p]);
              mismatches++;
            end
          end
        end
      end
    end
    outstanding <= pending_counts.size();
  end

endmodule

// ===== test/three_phase_sine_pwm_compare_tb.sv =====
// Testbench top for the three-phase sine PWM compare block: clock, reset,
// angle stimulus, compare back-pressure, register settings and the verdict.
// Depends on spwm_pkg, spwm_if, compare_count_checker and the block itself.
module three_phase_sine_pwm_compare_tb;
  import spwm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int NUM_SETTINGS      = 8;
  localparam int ITEMS_PER_SETTING = 200;
  localparam int DRAIN_CYCLES      = 10;
  localparam int HOLD_CYCLES       = 300;
  localparam int IDLE_LIMIT        = 2000;

  localparam logic [31:0] DIRECTED [18] = '{
    32'h0000_0000, 32'h0000_FFFF, 32'h0000_8000, 32'h4000_FFFF, 32'h8000_FFFF,
    32'hC000_FFFF, 32'hFFFF_FFFF, 32'h3FFF_8000, 32'h5555_8000, 32'hAAAA_8000,
    32'hFFFF_0000, 32'h0001_0001, 32'h000F_FFFF, 32'h0010_FFFF, 32'h2AAA_9C40,
    32'hD555_7FFF, 32'h7FFF_FFFF, 32'hBFFF_3039
  };

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    mismatches;
  int                    outstanding;
  int                    quiet_cycles;
  int                    items_sent;
  int                    settings_used;
  bit                    steady;

  spwm_angle_if angle_ch();
  spwm_cmp_if   cmp_ch();

  three_phase_sine_pwm_compare uut (
    .clk       (clk),
    .rst       (rst),
    .angle_ch  (angle_ch),
    .cmp_ch    (cmp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  compare_count_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .angle_ch    (angle_ch),
    .cmp_ch      (cmp_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst || (angle_ch.valid && angle_ch.ready) || (cmp_ch.valid && cmp_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("[three_phase_sine_pwm_compare] ERROR");
        $finish;
      end
    end
  end

  // The receiver holds ready low for a long stretch twice while the sender
  // keeps offering angles, so the pipeline fills and stalls its input.
  initial begin
    int gap;
    int taken;
    taken = 0;
    forever begin
      gap = steady ? 0 : $urandom_range(0, 4);
      if (taken == 400 || taken == 1300) begin
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        cmp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      cmp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!cmp_ch.valid) @(posedge clk);
      taken++;
    end
  end

  task automatic send_item(input logic [ANGLE_W-1:0] angle, input logic [MOD_W-1:0] m);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      angle_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    angle_ch.valid      <= 1'b1;
    angle_ch.elec_angle <= angle;
    angle_ch.mod_index  <= m;
    @(posedge clk);
    while (!angle_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_idle();
    angle_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic load_setting(input logic [CFG_DATA_W-1:0] per, input logic [CFG_DATA_W-1:0] lo,
                              input logic [CFG_DATA_W-1:0] hi);
    wait_idle();
    write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    write_reg(CFG_TIMER_PERIOD, per);
    write_reg(CFG_DUTY_FLOOR, lo);
    write_reg(CFG_DUTY_CEILING, hi);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    logic [ANGLE_W-1:0]    angle;
    logic [MOD_W-1:0]      m;
    logic [CFG_DATA_W-1:0] per_w;
    logic [CFG_DATA_W-1:0] lo_w;
    logic [CFG_DATA_W-1:0] hi_w;
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= CFG_TIMER_PERIOD;
    cfg_wdata           <= '0;
    angle_ch.valid      <= 1'b0;
    angle_ch.elec_angle <= '0;
    angle_ch.mod_index  <= '0;
    quiet_cycles        <= 0;
    steady        = 1'b0;
    items_sent    = 0;
    settings_used = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[n]) begin
      send_item(DIRECTED[n][31:16], DIRECTED[n][15:0]);
    end

    for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
      case (ph)
        0: begin per_w = 17'd65535;  lo_w = 17'd0;      hi_w = 17'd131071; end
        1: begin per_w = 17'h10000;  lo_w = 17'd0;      hi_w = 17'd65536;  end
        2: begin per_w = 17'($urandom); lo_w = 17'd40000; hi_w = 17'd20000; end
        3: begin per_w = 17'd65535;  lo_w = 17'd131071; hi_w = 17'd131071; end
        4: begin per_w = 17'd1;      lo_w = 17'd0;      hi_w = 17'd0;      end
        5: begin per_w = 17'($urandom); lo_w = 17'd6554; hi_w = 17'd58982; end
        default: begin
          per_w = 17'($urandom);
          lo_w  = 17'($urandom_range(0, 70000));
          hi_w  = 17'($urandom);
        end
      endcase
      load_setting(per_w, lo_w, hi_w);
      for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
        if (n % 50 == 0) begin
          steady = ($urandom_range(0, 3) == 0);
        end
        if ($urandom_range(0, 3) == 0) begin
          angle = {2'($urandom_range(0, 3)),
                   ($urandom_range(0, 1) == 1) ? 14'($urandom_range(0, 15))
                                               : 14'($urandom_range(16368, 16383))};
        end else begin
          angle = 16'($urandom);
        end
        case ($urandom_range(0, 3))
          0: m = 16'($urandom);
          1: m = 16'($urandom_range(0, 32768));
          2: begin
            case ($urandom_range(0, 4))
              0: m = 16'h0000;
              1: m = 16'h0001;
              2: m = 16'h7FFF;
              3: m = 16'h8000;
              default: m = 16'hFFFF;
            endcase
          end
          default: m = 16'($urandom_range(32760, 32776));
        endcase
        send_item(angle, m);
      end
    end

    wait_idle();
    $display("Sent %0d angle transfers under %0d register settings, including zero period,",
             items_sent, settings_used + 1);
    $display("floor above ceiling, saturated counts and long output stalls.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("[three_phase_sine_pwm_compare] OK");
    end else begin
      $display("[three_phase_sine_pwm_compare] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/spwm_pkg.sv
rtl/spwm_if.sv
rtl/spwm_phase.sv
rtl/three_phase_sine_pwm_compare.sv
test/compare_count_checker.sv
test/three_phase_sine_pwm_compare_tb.sv
